/* rtl/fba_pkg.sv */
// Shared constants and types for the frame bitmap allocator.
// No dependencies; used by rtl/frame_bitmap_allocator.sv.
package fba_pkg;

  // Map geometry
  localparam int MAX_FRAMES = 4096;
  localparam int WORD_BITS  = 32;
  localparam int MAP_WORDS  = MAX_FRAMES / WORD_BITS;
  localparam int WORD_IDX_W = $clog2(MAP_WORDS);
  localparam int BIT_IDX_W  = $clog2(WORD_BITS);

  // Field and register widths
  localparam int FRAME_W = 12;
  localparam int COUNT_W = 13;
  localparam int LIM_W   = COUNT_W - BIT_IDX_W;

  localparam logic [WORD_BITS-1:0] WORD_FULL = '1;
  localparam logic [COUNT_W-1:0]   COUNT_RESET = COUNT_W'(MAX_FRAMES);

  // Request command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SET,
    ST_CLEAR,
    ST_DONE
  } state_t;

endpackage

/* rtl/frame_bitmap_allocator.sv */
// Page-frame allocator: one-bit-per-frame map in a 128x32 memory, first-fit search.
// Depends on rtl/fba_pkg.sv.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+----------------------------------------
//   req     | in        | req_valid/req_ready  | command, entry_frame, kernel_page,
//           |           |                      | writable_page
//   rsp     | out       | rsp_valid/rsp_ready  | frame, present, writable, user, full_res
//   cfg     | in        | cfg_valid/cfg_ready  | cfg_data (frame_count)
//
// An allocation with entry_frame 0 scans the map one word per cycle through the single
// memory read port, over at most min(frame_count/32, 128) words, and stops at the first
// word with a free bit, else reports full. A free with a nonzero frame reads the word,
// writes it back and then responds; other requests go straight to the response step. One
// request is in work at a time; req_ready is high only while idle. The response register
// holds a result while rsp_ready is low, and the next request is accepted meanwhile. Reset
// clears the map through per-word valid bits, so no clearing pass is needed.
module frame_bitmap_allocator (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fba_pkg::COUNT_W-1:0]   cfg_data,
  // request
  input  logic                          req_valid,
  output logic                          req_ready,
  input  logic                          command,
  input  logic [fba_pkg::FRAME_W-1:0]   entry_frame,
  input  logic                          kernel_page,
  input  logic                          writable_page,
  // response
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output logic [fba_pkg::FRAME_W-1:0]   frame,
  output logic                          present,
  output logic                          writable,
  output logic                          user,
  output logic                          full_res
);

  fba_pkg::state_t state, state_next;

  logic [fba_pkg::COUNT_W-1:0]    frame_count;

  // map memory and per-word valid bits
  logic [fba_pkg::WORD_BITS-1:0]  map_mem [fba_pkg::MAP_WORDS];
  logic [fba_pkg::MAP_WORDS-1:0]  map_vld;
  logic [fba_pkg::WORD_BITS-1:0]  rd_data;
  logic                           rd_vld;
  logic [fba_pkg::WORD_BITS-1:0]  rd_word;

  logic                           rd_en;
  logic [fba_pkg::WORD_IDX_W-1:0] rd_addr;
  logic                           wr_en;
  logic [fba_pkg::WORD_IDX_W-1:0] wr_addr;
  logic [fba_pkg::WORD_BITS-1:0]  wr_data;

  // scan sequencer
  logic [fba_pkg::LIM_W-1:0]      scan_addr;
  logic [fba_pkg::LIM_W-1:0]      scan_lim;
  logic [fba_pkg::LIM_W-1:0]      count_words;
  logic [fba_pkg::WORD_IDX_W-1:0] chk_addr;
  logic                           chk_pend;
  logic                           chk_hit;

  // held request and result under construction
  logic [fba_pkg::WORD_IDX_W-1:0] req_word;
  logic [fba_pkg::BIT_IDX_W-1:0]  req_bit;
  logic [fba_pkg::FRAME_W-1:0]    res_frame;
  logic                           res_present;
  logic                           res_writable;
  logic                           res_user;
  logic                           res_full;

  logic [fba_pkg::WORD_BITS-1:0]  low_clear;
  logic [fba_pkg::BIT_IDX_W-1:0]  low_idx;
  logic                           req_fire;
  logic                           rsp_free;

  assign cfg_ready = 1'b1;
  assign req_ready = (state == fba_pkg::ST_IDLE);
  assign req_fire  = req_valid && req_ready;
  assign rsp_free  = !rsp_valid || rsp_ready;

  // Limit the searched words to the map size
  assign count_words = frame_count[fba_pkg::COUNT_W-1:fba_pkg::BIT_IDX_W];
  assign scan_lim    = (count_words > fba_pkg::LIM_W'(fba_pkg::MAP_WORDS)) ?
                       fba_pkg::LIM_W'(fba_pkg::MAP_WORDS) : count_words;

  // A word never written reads as all free
  assign rd_word = rd_vld ? rd_data : '0;
  assign chk_hit = chk_pend && (rd_word != fba_pkg::WORD_FULL);

  // Isolate the lowest clear bit and encode its position
  assign low_clear = ~rd_word & (rd_word + fba_pkg::WORD_BITS'(1));

  always_comb begin
    low_idx = '0;
    for (int i = 0; i < fba_pkg::WORD_BITS; i++) begin
      if (low_clear[i]) begin
        low_idx = low_idx | fba_pkg::BIT_IDX_W'(i);
      end
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= fba_pkg::COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      frame_count <= cfg_data;
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fba_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and memory port control
  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    rd_addr    = scan_addr[fba_pkg::WORD_IDX_W-1:0];
    wr_en      = 1'b0;
    wr_addr    = chk_addr;
    wr_data    = rd_word | low_clear;
    unique case (state)
      fba_pkg::ST_IDLE: begin
        if (req_fire) begin
          if (command == fba_pkg::CMD_FREE) begin
            if (entry_frame != '0) begin
              rd_en      = 1'b1;
              rd_addr    = entry_frame[fba_pkg::FRAME_W-1:fba_pkg::BIT_IDX_W];
              state_next = fba_pkg::ST_CLEAR;
            end else begin
              state_next = fba_pkg::ST_DONE;
            end
          end else if (entry_frame != '0) begin
            state_next = fba_pkg::ST_DONE;
          end else begin
            state_next = fba_pkg::ST_SCAN;
          end
        end
      end
      fba_pkg::ST_SCAN: begin
        priority if (chk_hit) begin
          state_next = fba_pkg::ST_SET;
        end else if (scan_addr < scan_lim) begin
          rd_en = 1'b1;
        end else begin
          state_next = fba_pkg::ST_DONE;
        end
      end
      fba_pkg::ST_SET: begin
        wr_en      = 1'b1;
        state_next = fba_pkg::ST_DONE;
      end
      fba_pkg::ST_CLEAR: begin
        wr_en      = 1'b1;
        wr_addr    = req_word;
        wr_data    = rd_word & ~(fba_pkg::WORD_BITS'(1) << req_bit);
        state_next = fba_pkg::ST_DONE;
      end
      fba_pkg::ST_DONE: begin
        if (rsp_free) begin
          state_next = fba_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = fba_pkg::ST_IDLE;
      end
    endcase
  end

  // Map memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      map_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= map_mem[rd_addr];
    end
  end

  // Word valid bits: reset marks every word as all free
  always_ff @(posedge clk) begin
    if (rst) begin
      map_vld <= '0;
      rd_vld  <= 1'b0;
    end else begin
      if (wr_en) begin
        map_vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= map_vld[rd_addr];
      end
    end
  end

  // Hold request fields, advance the scan, build the result
  always_ff @(posedge clk) begin
    unique case (state)
      fba_pkg::ST_IDLE: begin
        if (req_fire) begin
          req_word  <= entry_frame[fba_pkg::FRAME_W-1:fba_pkg::BIT_IDX_W];
          req_bit   <= entry_frame[fba_pkg::BIT_IDX_W-1:0];
          scan_addr <= '0;
          chk_pend  <= 1'b0;
          res_full  <= 1'b0;
          if (command == fba_pkg::CMD_FREE) begin
            res_frame    <= '0;
            res_present  <= 1'b0;
            res_writable <= 1'b0;
            res_user     <= 1'b0;
          end else begin
            res_frame    <= entry_frame;
            res_present  <= 1'b1;
            res_writable <= writable_page;
            res_user     <= !kernel_page;
          end
        end
      end
      fba_pkg::ST_SCAN: begin
        if (!chk_hit) begin
          if (rd_en) begin
            scan_addr <= scan_addr + fba_pkg::LIM_W'(1);
            chk_addr  <= scan_addr[fba_pkg::WORD_IDX_W-1:0];
            chk_pend  <= 1'b1;
          end else begin
            // map exhausted: report full
            res_frame    <= '0;
            res_present  <= 1'b0;
            res_writable <= 1'b0;
            res_user     <= 1'b0;
            res_full     <= 1'b1;
          end
        end
      end
      fba_pkg::ST_SET: begin
        res_frame <= {chk_addr, low_idx};
      end
      default: begin
      end
    endcase
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == fba_pkg::ST_DONE && rsp_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == fba_pkg::ST_DONE && rsp_free) begin
      frame    <= res_frame;
      present  <= res_present;
      writable <= res_writable;
      user     <= res_user;
      full_res <= res_full;
    end
  end

  // Checks
  a_write_states: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == fba_pkg::ST_SET || state == fba_pkg::ST_CLEAR))
    else $error("map write outside set or clear step");

  a_set_has_free: assert property (@(posedge clk) disable iff (rst)
    state == fba_pkg::ST_SET |-> rd_word != fba_pkg::WORD_FULL)
    else $error("set step entered on a full word");

  a_set_marks_valid: assert property (@(posedge clk) disable iff (rst)
    state == fba_pkg::ST_SET |=> map_vld[chk_addr])
    else $error("allocated word not marked valid");

  a_full_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && full_res |-> !present && !writable && !user && frame == '0)
    else $error("full response carries entry bits");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == fba_pkg::ST_SCAN && rd_en |-> scan_addr < scan_lim)
    else $error("scan read beyond frame count");

endmodule

/* verif/tb_frame_bitmap_allocator.sv */
// Self-checking testbench for frame_bitmap_allocator: request driver, response checker and
// a first-fit frame map predictor, with bursty requests and a stalling response side.
// Depends on rtl/fba_pkg.sv and rtl/frame_bitmap_allocator.sv.
`timescale 1ns / 1ps

module tb_frame_bitmap_allocator;

  localparam int IDLE_LIMIT  = 2000;
  localparam int DRAIN_WAIT  = fba_pkg::MAP_WORDS + 12;
  localparam int LONG_HOLD   = 300;

  typedef struct packed {
    logic                        cmd;
    logic [fba_pkg::FRAME_W-1:0] ef;
    logic                        kern;
    logic                        wr;
  } page_req_t;

  typedef struct packed {
    logic [fba_pkg::FRAME_W-1:0] frame;
    logic                        present;
    logic                        writable;
    logic                        user;
    logic                        full;
  } page_entry_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [fba_pkg::COUNT_W-1:0] cfg_data = fba_pkg::COUNT_RESET;
  logic                        req_valid = 1'b0;
  logic                        req_ready;
  logic                        command = fba_pkg::CMD_ALLOC;
  logic [fba_pkg::FRAME_W-1:0] entry_frame = '0;
  logic                        kernel_page = 1'b0;
  logic                        writable_page = 1'b0;
  logic                        rsp_valid;
  logic                        rsp_ready = 1'b0;
  logic [fba_pkg::FRAME_W-1:0] frame;
  logic                        present;
  logic                        writable;
  logic                        user;
  logic                        full_res;

  // Predictor state
  logic [fba_pkg::WORD_BITS-1:0] frame_map_copy [fba_pkg::MAP_WORDS];
  logic [fba_pkg::COUNT_W-1:0]   frame_count_copy;

  page_req_t   page_reqs[$];
  page_entry_t predicted_entries[$];
  page_req_t   cur_req;
  page_entry_t want_entry;
  int          unanswered = 0;
  int          err_count = 0;
  int          burst_left;
  int          gap_left;
  int          idle_cycles;
  logic        hold_arm = 1'b0;
  int          hold_left;
  bit          hold_used;
  int          seg_left;
  int          stall_pct;

  frame_bitmap_allocator dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .command       (command),
    .entry_frame   (entry_frame),
    .kernel_page   (kernel_page),
    .writable_page (writable_page),
    .rsp_valid     (rsp_valid),
    .rsp_ready     (rsp_ready),
    .frame         (frame),
    .present       (present),
    .writable      (writable),
    .user          (user),
    .full_res      (full_res)
  );

  always #5 clk = ~clk;

  // Compute the page entry for one request and update the map copy
  function automatic page_entry_t predict_page_entry(page_req_t r);
    page_entry_t res;
    int unsigned words;
    int unsigned w;
    int unsigned b;
    bit          found;
    res = '0;
    if (r.cmd == fba_pkg::CMD_ALLOC) begin
      if (r.ef != '0) begin
        res.frame    = r.ef;
        res.present  = 1'b1;
        res.writable = r.wr;
        res.user     = ~r.kern;
      end else begin
        words = 32'(frame_count_copy) / fba_pkg::WORD_BITS;
        if (words > fba_pkg::MAP_WORDS) words = fba_pkg::MAP_WORDS;
        found = 1'b0;
        // First fit: lowest clear bit in the searched words
        for (w = 0; w < words && !found; w++) begin
          if (frame_map_copy[w] != fba_pkg::WORD_FULL) begin
            for (b = 0; b < fba_pkg::WORD_BITS && !found; b++) begin
              if (!frame_map_copy[w][b]) begin
                found = 1'b1;
                frame_map_copy[w][b] = 1'b1;
                res.frame    = fba_pkg::FRAME_W'(w * fba_pkg::WORD_BITS + b);
                res.present  = 1'b1;
                res.writable = r.wr;
                res.user     = ~r.kern;
              end
            end
          end
        end
        if (!found) res.full = 1'b1;
      end
    end else if (r.ef != '0) begin
      frame_map_copy[r.ef / fba_pkg::WORD_BITS][r.ef % fba_pkg::WORD_BITS] = 1'b0;
    end
    return res;
  endfunction

  function automatic void check_field(string name, logic [fba_pkg::FRAME_W-1:0] exp_v,
                                      logic [fba_pkg::FRAME_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
      err_count++;
    end
  endfunction

  // Request driver: bursts of requests with random gaps; predict on acceptance
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
      frame_count_copy = fba_pkg::COUNT_RESET;
      foreach (frame_map_copy[i]) frame_map_copy[i] = '0;
    end else begin
      if (cfg_valid && cfg_ready) frame_count_copy = cfg_data;
      if (req_valid && req_ready) predicted_entries.push_back(predict_page_entry(cur_req));
      if (!req_valid || req_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          req_valid <= 1'b0;
        end else if (page_reqs.size() > 0) begin
          cur_req = page_reqs.pop_front();
          command       <= cur_req.cmd;
          entry_frame   <= cur_req.ef;
          kernel_page   <= cur_req.kern;
          writable_page <= cur_req.wr;
          req_valid     <= 1'b1;
          if (burst_left == 0) burst_left = $urandom_range(1, 32);
          burst_left--;
          if (burst_left == 0)
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Response side: stall density changes per segment, plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
      hold_left = 0;
      hold_used = 1'b0;
      seg_left = 0;
      stall_pct = 0;
    end else begin
      if (hold_arm && !hold_used) begin
        hold_used = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (seg_left == 0) begin
        seg_left = $urandom_range(16, 96);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 25;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      seg_left--;
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Response checker: compare each accepted entry with the oldest prediction
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (predicted_entries.size() == 0) begin
        $display("%0t: unexpected response, expected none, got frame %0d full %0d",
                 $time, frame, full_res);
        err_count++;
      end else begin
        want_entry = predicted_entries.pop_front();
        unanswered--;
        check_field("frame", want_entry.frame, frame);
        check_field("present", fba_pkg::FRAME_W'(want_entry.present),
                    fba_pkg::FRAME_W'(present));
        check_field("writable", fba_pkg::FRAME_W'(want_entry.writable),
                    fba_pkg::FRAME_W'(writable));
        check_field("user", fba_pkg::FRAME_W'(want_entry.user), fba_pkg::FRAME_W'(user));
        check_field("full_res", fba_pkg::FRAME_W'(want_entry.full),
                    fba_pkg::FRAME_W'(full_res));
      end
    end
  end

  // Watchdog: end the run when no handshake happens for too long
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: timeout, no handshake for %0d cycles", $time, IDLE_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic add_req(logic cmd, logic [fba_pkg::FRAME_W-1:0] ef, logic kern, logic wr);
    page_req_t r;
    r.cmd = cmd;
    r.ef = ef;
    r.kern = kern;
    r.wr = wr;
    page_reqs.push_back(r);
    unanswered++;
  endtask

  // Mix of new-frame allocs, keep allocs, frees of low frames and stray frees
  task automatic add_random_reqs(int n, int free_span);
    int pick;
    int k;
    for (k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45)
        add_req(fba_pkg::CMD_ALLOC, '0, 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
      else if (pick < 65)
        add_req(fba_pkg::CMD_ALLOC, fba_pkg::FRAME_W'($urandom_range(1, 4095)),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      else if (pick < 92)
        add_req(fba_pkg::CMD_FREE, fba_pkg::FRAME_W'($urandom_range(1, free_span)),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      else
        add_req(fba_pkg::CMD_FREE,
                fba_pkg::FRAME_W'($urandom_range(0, 1) ? 0 : $urandom_range(1, 4095)),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
  endtask

  // Wait until every queued request has been answered
  task automatic wait_drained();
    while (unanswered != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_frame_count(logic [fba_pkg::COUNT_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Stimulus sequence
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset count: first fit from frame 0, keep, free, reuse
    add_req(fba_pkg::CMD_ALLOC, '0, 1'b0, 1'b0);
    add_req(fba_pkg::CMD_ALLOC, '0, 1'b1, 1'b1);
    add_req(fba_pkg::CMD_ALLOC, 12'd4095, 1'b0, 1'b1);
    add_req(fba_pkg::CMD_ALLOC, 12'd1, 1'b1, 1'b0);
    add_req(fba_pkg::CMD_FREE, '0, 1'b1, 1'b1);
    add_req(fba_pkg::CMD_FREE, 12'd4095, 1'b0, 1'b0);
    add_req(fba_pkg::CMD_FREE, 12'd1, 1'b1, 1'b1);
    add_req(fba_pkg::CMD_ALLOC, '0, 1'b1, 1'b0);
    add_req(fba_pkg::CMD_ALLOC, '0, 1'b0, 1'b1);
    add_req(fba_pkg::CMD_FREE, 12'd2048, 1'b0, 1'b1);
    wait_drained();

    // No frames managed: search finds nothing
    write_frame_count('0);
    add_req(fba_pkg::CMD_ALLOC, '0, 1'b0, 1'b1);
    add_req(fba_pkg::CMD_ALLOC, 12'd5, 1'b1, 1'b1);
    add_req(fba_pkg::CMD_FREE, 12'd2, 1'b0, 1'b0);
    wait_drained();

    // Partial word is not searched
    write_frame_count(13'd31);
    add_req(fba_pkg::CMD_ALLOC, '0, 1'b1, 1'b1);
    wait_drained();

    write_frame_count(13'd32);
    add_req(fba_pkg::CMD_ALLOC, '0, 1'b0, 1'b0);
    add_req(fba_pkg::CMD_ALLOC, '0, 1'b1, 1'b1);
    add_req(fba_pkg::CMD_FREE, 12'd0, 1'b0, 1'b0);
    wait_drained();

    // Count beyond the map: search clamped to all words
    write_frame_count('1);
    add_random_reqs(80, 200);
    wait_drained();

    // Small maps that run full often
    write_frame_count(13'd96);
    add_random_reqs(120, 95);
    wait_drained();

    write_frame_count(13'd33);
    add_random_reqs(60, 40);
    wait_drained();

    // Hold off responses for a long stretch so the request side backs up
    write_frame_count(13'd256);
    hold_arm <= 1'b1;
    add_random_reqs(80, 255);
    wait_drained();

    write_frame_count(fba_pkg::COUNT_RESET);
    add_random_reqs(110, 300);
    wait_drained();

    repeat (DRAIN_WAIT) @(posedge clk);
    if (err_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

/* sim.f */
rtl/fba_pkg.sv
rtl/frame_bitmap_allocator.sv
verif/tb_frame_bitmap_allocator.sv
